// File: rtl/core/ccnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccnt_pkg
// Shared widths, defaults and operation codes for the coprime count engine.
// ----------------------------------------------------------------------------
package ccnt_pkg;

  localparam int VAL_W    = 17;
  localparam int OPER_W   = 2;
  localparam int OUT_W    = 20;
  localparam int S_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

  // trial divisors never exceed the square root of a VAL_W-bit value
  localparam int DIV_W  = (VAL_W + 1) / 2;
  localparam int JSQ_W  = 2 * DIV_W;
  localparam int DCNT_W = $clog2(VAL_W);

  // distinct prime factors of a VAL_W-bit value
  localparam int MAX_PRIMES = 6;
  localparam int PIDX_W     = $clog2(MAX_PRIMES + 1);

  localparam int DEF_MAX_VALUE  = 131072;
  localparam int DEF_COUNT_BITS = 20;

  typedef enum logic [OPER_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } oper_t;

endpackage : ccnt_pkg
`default_nettype wire

// File: rtl/core/coprime_count_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An insert runs trial divisors j up to sqrt(v) through the divider and bumps
//   count(j) and count(v/j) for each hit; a query factors v the same way, then
//   sums count(d) over the 2^k subsets of its k distinct primes; a clear zeroes all.
// Throughput: one transaction at a time, set by the shared bit-serial divider.
// Reset: synchronous; a clearing pass zeroes every entry of the counter
//   memory, with s_axis_tready low until it ends.
// ----------------------------------------------------------------------------
// coprime_count_engine_unit
// Divisor counter table with insert, coprime-count query and clear. A query
// factors its value and sums +/- count(d) over the square-free divisors d.
// ----------------------------------------------------------------------------
module coprime_count_engine_unit
  import ccnt_pkg::*;
#(
  parameter int MAX_VALUE  = DEF_MAX_VALUE,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,   // [16:0] value
  input  wire logic [OPER_W-1:0]   s_axis_tuser,   // [1:0] operation
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [M_DATA_W-1:0]      m_axis_tdata    // [19:0] coprime_count
);

  localparam int ADDR_W = $clog2(MAX_VALUE);
  localparam int ACC_W  = (COUNT_BITS + 8 > OUT_W + 2) ? COUNT_BITS + 8 : OUT_W + 2;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_INS_TEST = 11'b000_0000_0100,
    S_FAC_TEST = 11'b000_0000_1000,
    S_DIV      = 11'b000_0001_0000,
    S_INS_EVAL = 11'b000_0010_0000,
    S_FAC_EVAL = 11'b000_0100_0000,
    S_SUB_MUL  = 11'b000_1000_0000,
    S_RD       = 11'b001_0000_0000,
    S_WR       = 11'b010_0000_0000,
    S_FIN      = 11'b100_0000_0000
  } state_t;

  state_t                  state;
  logic                    is_query;
  logic [VAL_W-1:0]        n_q;
  logic [VAL_W-1:0]        m_q;
  logic [DIV_W-1:0]        j_q;
  logic [JSQ_W-1:0]        jsq_q;
  logic                    j_hit;
  logic                    second;
  logic [VAL_W-1:0]        div_quo;
  logic [DIV_W-1:0]        div_rem;
  logic [DCNT_W-1:0]       div_cnt;
  logic [VAL_W-1:0]        primes [MAX_PRIMES];
  logic [PIDX_W-1:0]       k_q;
  logic [PIDX_W-1:0]       i_q;
  logic [MAX_PRIMES-1:0]   mask_q;
  logic [VAL_W-1:0]        prod_q;
  logic signed [ACC_W-1:0] acc;
  logic [ADDR_W-1:0]       addr_q;

  logic [COUNT_BITS-1:0]   count_mem [MAX_VALUE];
  logic [COUNT_BITS-1:0]   rd_data;
  logic                    mem_we;
  logic [COUNT_BITS-1:0]   mem_wdata;

  logic [VAL_W-1:0]        in_value;
  oper_t                   in_oper;
  logic                    in_ok;
  logic [DIV_W:0]          rem_sh;
  logic                    rem_ge;
  logic [JSQ_W-1:0]        jsq_inc;
  logic [MAX_PRIMES-1:0]   last_mask;
  logic [2*VAL_W-1:0]      mul_full;
  logic [ACC_W-1:0]        rd_ext;
  logic [OUT_W-1:0]        result;

  assign s_axis_tready = (state == S_IDLE);
  assign in_value  = s_axis_tdata[VAL_W-1:0];
  assign in_oper   = oper_t'(s_axis_tuser);
  assign in_ok     = (in_value != '0) && (32'(in_value) < MAX_VALUE);
  assign rem_sh    = {div_rem, div_quo[VAL_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, j_q});
  assign jsq_inc   = jsq_q + JSQ_W'({j_q, 1'b1});
  assign last_mask = ~({MAX_PRIMES{1'b1}} << k_q);
  assign mul_full  = prod_q * primes[i_q];
  assign rd_ext    = ACC_W'(rd_data);

  always_comb begin
    if (acc[ACC_W-1]) begin
      result = '0;
    end else if (|acc[ACC_W-2:OUT_W]) begin
      result = '1;
    end else begin
      result = acc[OUT_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WR && !is_query && rd_data != {COUNT_BITS{1'b1}}) begin
      mem_we    = 1'b1;
      mem_wdata = rd_data + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[addr_q] <= mem_wdata;
    end
    rd_data <= count_mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      addr_q        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (addr_q == ADDR_W'(MAX_VALUE - 1)) begin
            state <= S_IDLE;
          end else begin
            addr_q <= addr_q + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            n_q   <= in_value;
            m_q   <= in_value;
            acc   <= '0;
            k_q   <= '0;
            j_hit <= 1'b0;
            case (in_oper)
              OP_CLEAR: begin
                addr_q <= '0;
                state  <= S_CLEAR;
              end
              OP_INSERT: begin
                is_query <= 1'b0;
                j_q      <= DIV_W'(1);
                jsq_q    <= JSQ_W'(1);
                if (in_ok) begin
                  state <= S_INS_TEST;
                end
              end
              OP_QUERY: begin
                is_query <= 1'b1;
                j_q      <= DIV_W'(2);
                jsq_q    <= JSQ_W'(4);
                state    <= in_ok ? S_FAC_TEST : S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_INS_TEST: begin
          if (jsq_q <= JSQ_W'(n_q)) begin
            div_quo <= n_q;
            div_rem <= '0;
            div_cnt <= DCNT_W'(VAL_W - 1);
            state   <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FAC_TEST: begin
          if (jsq_q <= JSQ_W'(m_q)) begin
            div_quo <= m_q;
            div_rem <= '0;
            div_cnt <= DCNT_W'(VAL_W - 1);
            state   <= S_DIV;
          end else begin
            // leftover equal to the last hit prime is already in the list
            if (m_q > VAL_W'(1) && !(j_hit && m_q == VAL_W'(j_q)) &&
                k_q < PIDX_W'(MAX_PRIMES)) begin
              primes[k_q[PIDX_W-1:0]] <= m_q;
              k_q <= k_q + PIDX_W'(1);
            end
            mask_q <= '0;
            i_q    <= '0;
            prod_q <= VAL_W'(1);
            state  <= S_SUB_MUL;
          end
        end
        S_DIV: begin
          div_rem <= rem_ge ? DIV_W'(rem_sh - {1'b0, j_q}) : rem_sh[DIV_W-1:0];
          div_quo <= {div_quo[VAL_W-2:0], rem_ge};
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == '0) begin
            state <= is_query ? S_FAC_EVAL : S_INS_EVAL;
          end
        end
        S_INS_EVAL: begin
          if (div_rem == '0) begin
            addr_q <= ADDR_W'(j_q);
            second <= (div_quo != VAL_W'(j_q));
            state  <= S_RD;
          end else begin
            j_q   <= j_q + DIV_W'(1);
            jsq_q <= jsq_inc;
            state <= S_INS_TEST;
          end
        end
        S_FAC_EVAL: begin
          if (div_rem == '0) begin
            if (!j_hit && k_q < PIDX_W'(MAX_PRIMES)) begin
              primes[k_q[PIDX_W-1:0]] <= VAL_W'(j_q);
              k_q <= k_q + PIDX_W'(1);
            end
            j_hit <= 1'b1;
            m_q   <= div_quo;
          end else begin
            j_hit <= 1'b0;
            j_q   <= j_q + DIV_W'(1);
            jsq_q <= jsq_inc;
          end
          state <= S_FAC_TEST;
        end
        S_SUB_MUL: begin
          if (i_q == k_q) begin
            addr_q <= ADDR_W'(prod_q);
            state  <= S_RD;
          end else begin
            if (mask_q[i_q]) begin
              prod_q <= mul_full[VAL_W-1:0];
            end
            i_q <= i_q + PIDX_W'(1);
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (is_query) begin
            acc <= (^mask_q) ? acc - $signed(rd_ext) : acc + $signed(rd_ext);
            if (mask_q == last_mask) begin
              state <= S_FIN;
            end else begin
              mask_q <= mask_q + MAX_PRIMES'(1);
              i_q    <= '0;
              prod_q <= VAL_W'(1);
              state  <= S_SUB_MUL;
            end
          end else if (second) begin
            second <= 1'b0;
            addr_q <= ADDR_W'(div_quo);
            state  <= S_RD;
          end else begin
            j_q   <= j_q + DIV_W'(1);
            jsq_q <= jsq_inc;
            state <= S_INS_TEST;
          end
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= M_DATA_W'(result);
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : coprime_count_engine_unit
`default_nettype wire

// File: tb/coprime_count_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coprime_count_engine_unit_tb
// Self-checking bench for the coprime count engine. Inserts, queries, clears
// and unused codes go in through the input stream. A local divisor table and
// Mobius sieve predict each query answer, which is compared with the output
// stream in order. Both sides idle at random, and one long output stall backs
// the block up.
// ----------------------------------------------------------------------------
module coprime_count_engine_unit_tb;
  import ccnt_pkg::*;

  localparam int     NVAL         = DEF_MAX_VALUE;
  localparam int     CNT_MAX      = (1 << DEF_COUNT_BITS) - 1;
  localparam longint OUT_MAX      = (64'd1 << OUT_W) - 1;
  localparam int     IDLE_LIMIT   = 4 * DEF_MAX_VALUE;
  localparam int     DRAIN_CYCLES = 10000;
  localparam int     HOLD_CYCLES  = 4000;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // [16:0] value
  logic [OPER_W-1:0]   s_axis_tuser  = '0;  // [1:0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // [19:0] coprime_count

  byte              mu_of [NVAL];
  int unsigned      tally [NVAL];
  logic [OUT_W-1:0] want_counts [$];
  int               mismatches  = 0;
  bit               calm        = 1'b0;
  int               hold_left   = 0;
  int               idle_cycles = 0;

  always #10 clk = ~clk;

  coprime_count_engine_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // prime sieve: flip sign per prime factor, zero on any square factor
  function automatic void build_mobius();
    bit composite [NVAL];
    int p;
    int k;
    foreach (mu_of[i]) mu_of[i] = 1;
    mu_of[0] = 0;
    for (p = 2; p < NVAL; p++) begin
      if (!composite[p]) begin
        for (k = p; k < NVAL; k += p) begin
          if (k != p) composite[k] = 1'b1;
          mu_of[k] = -mu_of[k];
        end
        if (p <= (NVAL - 1) / p) begin
          for (k = p * p; k < NVAL; k += p * p) mu_of[k] = 0;
        end
      end
    end
  endfunction

  function automatic void bump(int unsigned d);
    if (d < NVAL && tally[d] < CNT_MAX) tally[d]++;
  endfunction

  function automatic longint weight(int unsigned d);
    if (d >= NVAL) return 0;
    return longint'(mu_of[d]) * longint'(tally[d]);
  endfunction

  function automatic void update_divisor_table(oper_t op, logic [VAL_W-1:0] v);
    int unsigned n;
    int unsigned j;
    longint      sum;
    n   = 32'(v);
    sum = 0;
    case (op)
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = 0;
      end
      OP_INSERT: begin
        if (n < NVAL) begin
          for (j = 1; j * j <= n; j++) begin
            if (n % j == 0) begin
              bump(j);
              if (j * j != n) bump(n / j);
            end
          end
        end
      end
      OP_QUERY: begin
        if (n < NVAL) begin
          for (j = 1; j * j <= n; j++) begin
            if (n % j == 0) begin
              sum += weight(j);
              if (j * j != n) sum += weight(n / j);
            end
          end
        end
        if (sum < 0) sum = 0;
        if (sum > OUT_MAX) sum = OUT_MAX;
        want_counts.push_back(sum[OUT_W-1:0]);
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(oper_t op, logic [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(v);
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    update_divisor_table(op, v);
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned primes [6] = '{2, 3, 5, 7, 11, 13};
    int unsigned v;
    v = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(1, 360);
      5, 6: begin
        foreach (primes[i]) begin
          if ($urandom_range(0, 1) == 1) v *= primes[i];
        end
      end
      7:       v = $urandom_range(1, 4095);
      8:       v = $urandom_range(0, (1 << VAL_W) - 1);
      default: v = $urandom_range(0, 1);
    endcase
    return v[VAL_W-1:0];
  endfunction

  task automatic test_empty_table();
    send_item(OP_QUERY, 1);
    send_item(OP_QUERY, 30030);
  endtask

  task automatic test_field_extremes();
    send_item(OP_INSERT, 1);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 65536);
    send_item(OP_QUERY, 0);
    send_item(OP_QUERY, 1);
    send_item(OP_QUERY, '1);
    send_item(OP_QUERY, 65536);
  endtask

  task automatic test_shared_factors();
    int unsigned ins [5] = '{6, 10, 15, 30030, 7};
    int unsigned qry [4] = '{30, 1, 12, 30030};
    foreach (ins[i]) send_item(OP_INSERT, VAL_W'(ins[i]));
    foreach (qry[i]) send_item(OP_QUERY, VAL_W'(qry[i]));
  endtask

  task automatic test_unused_code();
    send_item(OP_NONE, 6);
    send_item(OP_QUERY, 5);
  endtask

  task automatic test_clear();
    send_item(OP_CLEAR, 0);
    send_item(OP_QUERY, 1);
    send_item(OP_INSERT, 9);
    send_item(OP_QUERY, 6);
  endtask

  // output held off while queries and inserts keep coming
  task automatic test_output_stall();
    int i;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 6; i++) begin
      send_item((i % 2 == 0) ? OP_QUERY : OP_INSERT, VAL_W'($urandom_range(2, 64)));
    end
  endtask

  task automatic test_random_mix(int n_items);
    int    sent;
    int    pick;
    oper_t op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 14) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 10)      op = OP_NONE;
      else if (pick < 12) op = OP_CLEAR;
      else if (pick < 55) op = OP_INSERT;
      else                op = OP_QUERY;
      send_item(op, pick_value());
      if (op != OP_NONE) sent++;
    end
  endtask

  task automatic test_steady_stream();
    int i;
    calm = 1'b1;
    for (i = 0; i < 15; i++) begin
      send_item(($urandom_range(0, 1) == 1) ? OP_QUERY : OP_INSERT, pick_value());
    end
  endtask

  // output side: random stall bursts, plus the long hold when requested
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (want_counts.size() == 0) begin
        $error("coprime_count: unexpected transaction, actual %0d",
               m_axis_tdata[OUT_W-1:0]);
        mismatches++;
      end else begin
        want = want_counts.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want) begin
          $error("coprime_count mismatch: expected %0d, actual %0d",
                 want, m_axis_tdata[OUT_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    build_mobius();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_field_extremes();
    test_shared_factors();
    test_unused_code();
    test_clear();
    test_output_stall();
    test_random_mix(45);
    test_steady_stream();
    s_axis_tvalid <= 1'b0;
    while (want_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
